// ----- hdl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants of the dual encoder speed meter.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int POS_W       = 32;
    localparam int ACC_W       = 32;
    localparam int CNT_W       = 10;
    localparam int GEAR_W      = 8;
    localparam int PPR_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int FIELD_W     = 16;
    localparam int SCALED_W    = ACC_W + 1;
    localparam int DIV_W       = 32;
    localparam int DIVISOR_W   = GEAR_W + PPR_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int RPM_SCALE   = 60;

    localparam logic [CNT_W-1:0]  SAMPLE_TICKS_RST = CNT_W'(10);
    localparam logic [CNT_W-1:0]  WINDOWS_RST      = CNT_W'(100);
    localparam logic [GEAR_W-1:0] GEAR_RST         = GEAR_W'(30);
    localparam logic [PPR_W-1:0]  PPR_RST          = PPR_W'(13);

    typedef enum logic [1:0] {
        REG_SAMPLE_TICKS = 2'd0,
        REG_WINDOWS      = 2'd1,
        REG_GEAR_RATIO   = 2'd2,
        REG_PULSES       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_ACCUM,
        S_SCALE,
        S_START,
        S_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hdl/dsm_in_if.sv -----
// ----------------------------------------------------------------------------
// dsm_in_if
// Encoder event channel: edges, phases and time base tick.
// ----------------------------------------------------------------------------
interface dsm_in_if;
    logic valid;
    logic ready;
    logic left_edge;
    logic left_phase;
    logic right_edge;
    logic right_phase;
    logic ms_tick;

    modport source (
        output valid,
        output left_edge,
        output left_phase,
        output right_edge,
        output right_phase,
        output ms_tick,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_edge,
        input  left_phase,
        input  right_edge,
        input  right_phase,
        input  ms_tick,
        output ready
    );
endinterface

// ----- hdl/dsm_out_if.sv -----
// ----------------------------------------------------------------------------
// dsm_out_if
// Speed channel: window deltas, rpm report and their flags.
// ----------------------------------------------------------------------------
interface dsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_window_delta;
    logic signed [15:0] right_window_delta;
    logic signed [15:0] left_rpm;
    logic signed [15:0] right_rpm;
    logic               delta_valid;
    logic               rpm_valid;

    modport source (
        output valid,
        output left_window_delta,
        output right_window_delta,
        output left_rpm,
        output right_rpm,
        output delta_valid,
        output rpm_valid,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_window_delta,
        input  right_window_delta,
        input  left_rpm,
        input  right_rpm,
        input  delta_valid,
        input  rpm_valid,
        output ready
    );
endinterface

// ----- hdl/dsm_div.sv -----
// ----------------------------------------------------------------------------
// dsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dsm_pkg::DIV_W-1:0]      dividend,
    input  logic [dsm_pkg::DIVISOR_W-1:0]  divisor,
    output logic [dsm_pkg::DIV_W-1:0]      quotient,
    output dsm_pkg::div_status_t           stat
);
    import dsm_pkg::*;

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            count_next = DIV_CNT_W'(DIV_W);
            busy_next  = 1'b1;
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            count_next = count_reg - DIV_CNT_W'(1);
            if (rem_diff[DIVISOR_W])
            begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = rem_diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTH
    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("divider busy with no steps left");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

// ----- hdl/dual_encoder_speed_meter.sv -----
// ----------------------------------------------------------------------------
// dual_encoder_speed_meter
// A word that closes no window goes from S_IDLE to S_FINISH; one that closes
// a window passes S_DELTA and S_ACCUM; an rpm report adds S_SCALE, S_START,
// S_WAIT once per wheel on one shared serial divider. One word in flight.
// Reset clears positions, counters, accumulators and held outputs and loads
// the default configuration.
// ----------------------------------------------------------------------------
module dual_encoder_speed_meter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  dsm_pkg::cfg_index_t         cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0] cfg_data,
    dsm_in_if.sink                      encoder,
    dsm_out_if.source                   speed
);
    import dsm_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  sample_ticks_reg;
    logic [CNT_W-1:0]  windows_reg;
    logic [GEAR_W-1:0] gear_reg;
    logic [PPR_W-1:0]  ppr_reg;

    logic [POS_W-1:0] lpos_reg, lpos_next, rpos_reg, rpos_next;
    logic [POS_W-1:0] llast_reg, llast_next, rlast_reg, rlast_next;
    logic signed [ACC_W-1:0] lacc_reg, lacc_next, racc_reg, racc_next;
    logic [CNT_W-1:0] tick_reg, tick_next, window_reg, window_next;
    logic signed [FIELD_W-1:0] ldelta_reg, ldelta_next, rdelta_reg, rdelta_next;
    logic signed [FIELD_W-1:0] lrpm_reg, lrpm_next, rrpm_reg, rrpm_next;
    logic dflag_reg, dflag_next, rflag_reg, rflag_next;
    logic wheel_reg, wheel_next;
    logic neg_reg, neg_next;
    logic signed [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;

    logic out_valid_reg, out_load;

    logic [CNT_W-1:0]  tick_inc, window_inc;
    logic              close_window, close_report;
    logic signed [ACC_W-1:0] acc_sel;
    logic [GEAR_W-1:0] gear_eff;
    logic [PPR_W-1:0]  ppr_eff;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend, div_quotient;
    div_status_t       div_stat;
    logic signed [FIELD_W-1:0] rpm_sat;

    function automatic logic [POS_W-1:0] count_edge(logic [POS_W-1:0] pos,
                                                    logic edge_in, logic phase);
        logic [POS_W-1:0] res;
        res = pos;
        if (edge_in)
        begin
            res = phase ? pos + POS_W'(1) : pos - POS_W'(1);
        end
        return res;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_delta(logic [POS_W-1:0] d);
        logic [POS_W-FIELD_W:0] upper;
        logic signed [FIELD_W-1:0] res;
        upper = d[POS_W-1:FIELD_W-1];
        if (!d[POS_W-1] && (|upper))
        begin
            res = 16'sh7FFF;
        end
        else if (d[POS_W-1] && !(&upper))
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = d[FIELD_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ticks_reg <= SAMPLE_TICKS_RST;
            windows_reg      <= WINDOWS_RST;
            gear_reg         <= GEAR_RST;
            ppr_reg          <= PPR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_TICKS: sample_ticks_reg <= cfg_data[CNT_W-1:0];
                REG_WINDOWS:      windows_reg      <= cfg_data[CNT_W-1:0];
                REG_GEAR_RATIO:   gear_reg         <= cfg_data[GEAR_W-1:0];
                REG_PULSES:       ppr_reg          <= cfg_data[PPR_W-1:0];
                default:          ;
            endcase
        end
    end

    assign tick_inc     = tick_reg + CNT_W'(1);
    assign window_inc   = window_reg + CNT_W'(1);
    assign close_window = encoder.ms_tick && (tick_inc >= sample_ticks_reg);
    assign close_report = window_inc >= windows_reg;
    assign acc_sel      = wheel_reg ? racc_reg : lacc_reg;
    assign gear_eff     = (gear_reg == '0) ? GEAR_W'(1) : gear_reg;
    assign ppr_eff      = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
    assign div_start    = (state_reg == S_START);
    assign div_dividend = scaled_reg[SCALED_W-1] ? DIV_W'(-scaled_reg) : DIV_W'(scaled_reg);
    assign out_load     = (state_reg == S_FINISH) && (!out_valid_reg || speed.ready);

    always_comb
    begin
        if (!neg_reg)
        begin
            rpm_sat = (div_quotient > DIV_W'(32767)) ? 16'sh7FFF
                                                     : div_quotient[FIELD_W-1:0];
        end
        else
        begin
            rpm_sat = (div_quotient > DIV_W'(32768)) ? 16'sh8000
                                                     : -div_quotient[FIELD_W-1:0];
        end
    end

    dsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (encoder.valid)
                begin
                    state_next = close_window ? S_DELTA : S_FINISH;
                end
            end
            S_DELTA:  state_next = S_ACCUM;
            S_ACCUM:  state_next = close_report ? S_SCALE : S_FINISH;
            S_SCALE:  state_next = S_START;
            S_START:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = wheel_reg ? S_FINISH : S_SCALE;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lpos_next    = lpos_reg;
        rpos_next    = rpos_reg;
        llast_next   = llast_reg;
        rlast_next   = rlast_reg;
        lacc_next    = lacc_reg;
        racc_next    = racc_reg;
        tick_next    = tick_reg;
        window_next  = window_reg;
        ldelta_next  = ldelta_reg;
        rdelta_next  = rdelta_reg;
        lrpm_next    = lrpm_reg;
        rrpm_next    = rrpm_reg;
        dflag_next   = dflag_reg;
        rflag_next   = rflag_reg;
        wheel_next   = wheel_reg;
        neg_next     = neg_reg;
        scaled_next  = scaled_reg;
        divisor_next = divisor_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (encoder.valid)
                begin
                    lpos_next  = count_edge(lpos_reg, encoder.left_edge,
                                            encoder.left_phase);
                    rpos_next  = count_edge(rpos_reg, encoder.right_edge,
                                            encoder.right_phase);
                    dflag_next = close_window;
                    rflag_next = 1'b0;
                    if (encoder.ms_tick)
                    begin
                        tick_next = close_window ? '0 : tick_inc;
                    end
                end
            end
            S_DELTA:
            begin
                ldelta_next = sat_delta(lpos_reg - llast_reg);
                rdelta_next = sat_delta(rpos_reg - rlast_reg);
                llast_next  = lpos_reg;
                rlast_next  = rpos_reg;
            end
            S_ACCUM:
            begin
                lacc_next   = lacc_reg + ACC_W'(ldelta_reg);
                racc_next   = racc_reg + ACC_W'(rdelta_reg);
                window_next = close_report ? '0 : window_inc;
                rflag_next  = close_report;
                wheel_next  = 1'b0;
            end
            S_SCALE:
            begin
                scaled_next  = SCALED_W'(acc_sel) * SCALED_W'(RPM_SCALE);
                divisor_next = DIVISOR_W'(gear_eff) * DIVISOR_W'(ppr_eff);
            end
            S_START:
            begin
                neg_next = scaled_reg[SCALED_W-1];
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (wheel_reg)
                    begin
                        rrpm_next = rpm_sat;
                        lacc_next = '0;
                        racc_next = '0;
                    end
                    else
                    begin
                        lrpm_next = rpm_sat;
                    end
                    wheel_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lpos_reg      <= '0;
            rpos_reg      <= '0;
            llast_reg     <= '0;
            rlast_reg     <= '0;
            lacc_reg      <= '0;
            racc_reg      <= '0;
            tick_reg      <= '0;
            window_reg    <= '0;
            ldelta_reg    <= '0;
            rdelta_reg    <= '0;
            lrpm_reg      <= '0;
            rrpm_reg      <= '0;
            dflag_reg     <= 1'b0;
            rflag_reg     <= 1'b0;
            wheel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lpos_reg   <= lpos_next;
            rpos_reg   <= rpos_next;
            llast_reg  <= llast_next;
            rlast_reg  <= rlast_next;
            lacc_reg   <= lacc_next;
            racc_reg   <= racc_next;
            tick_reg   <= tick_next;
            window_reg <= window_next;
            ldelta_reg <= ldelta_next;
            rdelta_reg <= rdelta_next;
            lrpm_reg   <= lrpm_next;
            rrpm_reg   <= rrpm_next;
            dflag_reg  <= dflag_next;
            rflag_reg  <= rflag_next;
            wheel_reg  <= wheel_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (speed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        scaled_reg  <= scaled_next;
        divisor_reg <= divisor_next;
        if (out_load)
        begin
            speed.left_window_delta  <= ldelta_reg;
            speed.right_window_delta <= rdelta_reg;
            speed.left_rpm           <= lrpm_reg;
            speed.right_rpm          <= rrpm_reg;
            speed.delta_valid        <= dflag_reg;
            speed.rpm_valid          <= rflag_reg;
        end
    end

    assign encoder.ready = (state_reg == S_IDLE);
    assign speed.valid   = out_valid_reg;

`ifndef SYNTH
    a_rpm_implies_delta: assert property (@(posedge clk) disable iff (!rst_n)
        speed.valid && speed.rpm_valid |-> speed.delta_valid)
        else $error("rpm report without a closed window");
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> state_reg == S_WAIT)
        else $error("divider active outside the wait state");
    a_no_tick_direct: assert property (@(posedge clk) disable iff (!rst_n)
        encoder.valid && encoder.ready && !encoder.ms_tick |=> state_reg == S_FINISH)
        else $error("word without tick did not go straight to finish");
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !speed.valid |=> speed.valid)
        else $error("finished word not presented");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual encoder speed meter. A short table of
// encoder words, some with hand-read results, comes first. Random words follow
// under a series of register settings and handshake pressure modes. A
// one-way burst inside a single window then drives the rpm values into
// saturation. Every speed word is checked field by field against its hand-read
// result if the table has one, else a cycle-free model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import dsm_pkg::*;

    typedef struct packed {
        logic left_edge;
        logic left_phase;
        logic right_edge;
        logic right_phase;
        logic ms_tick;
    } enc_word_t;

    typedef struct packed {
        logic signed [15:0] left_delta;
        logic signed [15:0] right_delta;
        logic signed [15:0] left_rpm;
        logic signed [15:0] right_rpm;
        logic               delta_valid;
        logic               rpm_valid;
    } speed_word_t;

    typedef struct {
        enc_word_t   word;
        bit          known;
        speed_word_t want;
    } dir_row_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] st;
        logic [CFG_DATA_W-1:0] wpr;
        logic [CFG_DATA_W-1:0] gear;
        logic [CFG_DATA_W-1:0] ppr;
        int                    tick_pct;
    } phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dsm_in_if  encoder_ch ();
    dsm_out_if speed_ch ();

    dual_encoder_speed_meter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .encoder   (encoder_ch),
        .speed     (speed_ch)
    );

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int words_checked  = 0;
    int window_closes  = 0;
    int rpm_reports    = 0;
    int settings_used  = 0;

    speed_word_t pending_speed [$];
    speed_word_t seen;

    // meter mirror
    logic [CNT_W-1:0]        sample_ticks_r;
    logic [CNT_W-1:0]        windows_r;
    logic [GEAR_W-1:0]       gear_r;
    logic [PPR_W-1:0]        ppr_r;
    logic [POS_W-1:0]        left_pos;
    logic [POS_W-1:0]        right_pos;
    logic [POS_W-1:0]        left_last;
    logic [POS_W-1:0]        right_last;
    logic signed [ACC_W-1:0] left_acc;
    logic signed [ACC_W-1:0] right_acc;
    logic [CNT_W-1:0]        tick_cnt;
    logic [CNT_W-1:0]        window_cnt;
    logic signed [15:0]      left_delta;
    logic signed [15:0]      right_delta;
    logic signed [15:0]      left_rpm;
    logic signed [15:0]      right_rpm;

    always #5 clk = ~clk;

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] window_change(logic [POS_W-1:0] now,
                                                         logic [POS_W-1:0] last);
        logic signed [POS_W-1:0] diff;
        diff = now - last;
        return clamp16(longint'(diff));
    endfunction

    function automatic logic signed [15:0] shaft_rpm(logic signed [ACC_W-1:0] acc);
        longint g;
        longint p;
        g = (gear_r == 0) ? 1 : longint'(gear_r);
        p = (ppr_r == 0) ? 1 : longint'(ppr_r);
        return clamp16(longint'(acc) * RPM_SCALE / (g * p));
    endfunction

    function automatic speed_word_t advance_meter(enc_word_t w);
        speed_word_t r;
        r = '0;
        if (w.left_edge)
            left_pos = w.left_phase ? left_pos + POS_W'(1) : left_pos - POS_W'(1);
        if (w.right_edge)
            right_pos = w.right_phase ? right_pos + POS_W'(1) : right_pos - POS_W'(1);
        if (w.ms_tick)
        begin
            tick_cnt = tick_cnt + CNT_W'(1);
            if (tick_cnt >= sample_ticks_r)
            begin
                tick_cnt      = '0;
                r.delta_valid = 1'b1;
                left_delta    = window_change(left_pos, left_last);
                right_delta   = window_change(right_pos, right_last);
                left_last     = left_pos;
                right_last    = right_pos;
                left_acc      = left_acc + left_delta;
                right_acc     = right_acc + right_delta;
                window_cnt    = window_cnt + CNT_W'(1);
                if (window_cnt >= windows_r)
                begin
                    window_cnt  = '0;
                    r.rpm_valid = 1'b1;
                    left_rpm    = shaft_rpm(left_acc);
                    right_rpm   = shaft_rpm(right_acc);
                    left_acc    = '0;
                    right_acc   = '0;
                end
            end
        end
        r.left_delta  = left_delta;
        r.right_delta = right_delta;
        r.left_rpm    = left_rpm;
        r.right_rpm   = right_rpm;
        return r;
    endfunction

    task automatic check_speed(speed_word_t got);
        speed_word_t want;
        if (pending_speed.size() == 0)
        begin
            $error("speed word arrived with nothing pending");
            errors++;
        end
        else
        begin
            want = pending_speed.pop_front();
            words_checked++;
            if (got.left_delta !== want.left_delta)
            begin
                $error("left_window_delta: expected %0d, got %0d",
                       want.left_delta, got.left_delta);
                errors++;
            end
            if (got.right_delta !== want.right_delta)
            begin
                $error("right_window_delta: expected %0d, got %0d",
                       want.right_delta, got.right_delta);
                errors++;
            end
            if (got.left_rpm !== want.left_rpm)
            begin
                $error("left_rpm: expected %0d, got %0d", want.left_rpm, got.left_rpm);
                errors++;
            end
            if (got.right_rpm !== want.right_rpm)
            begin
                $error("right_rpm: expected %0d, got %0d", want.right_rpm, got.right_rpm);
                errors++;
            end
            if (got.delta_valid !== want.delta_valid)
            begin
                $error("delta_valid: expected %0b, got %0b",
                       want.delta_valid, got.delta_valid);
                errors++;
            end
            if (got.rpm_valid !== want.rpm_valid)
            begin
                $error("rpm_valid: expected %0b, got %0b", want.rpm_valid, got.rpm_valid);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && speed_ch.valid === 1'b1 && speed_ch.ready === 1'b1)
        begin
            seen = {speed_ch.left_window_delta, speed_ch.right_window_delta,
                    speed_ch.left_rpm, speed_ch.right_rpm,
                    speed_ch.delta_valid, speed_ch.rpm_valid};
            check_speed(seen);
        end
    end

    always @(negedge clk)
    begin
        speed_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic apply_word(enc_word_t w, bit known, speed_word_t want);
        speed_word_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            encoder_ch.valid <= 1'b0;
            @(negedge clk);
        end
        encoder_ch.valid <= 1'b1;
        {encoder_ch.left_edge, encoder_ch.left_phase, encoder_ch.right_edge,
         encoder_ch.right_phase, encoder_ch.ms_tick} <= w;
        do
            @(posedge clk);
        while (encoder_ch.ready !== 1'b1);
        predicted = advance_meter(w);
        pending_speed.push_back(known ? want : predicted);
        window_closes += predicted.delta_valid;
        rpm_reports   += predicted.rpm_valid;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        encoder_ch.valid <= 1'b0;
        while (pending_speed.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_meter(logic [CFG_DATA_W-1:0] st, logic [CFG_DATA_W-1:0] wpr,
                                 logic [CFG_DATA_W-1:0] gear, logic [CFG_DATA_W-1:0] ppr);
        write_reg(REG_SAMPLE_TICKS, st);
        write_reg(REG_WINDOWS, wpr);
        write_reg(REG_GEAR_RATIO, gear);
        write_reg(REG_PULSES, ppr);
        @(negedge clk);
        cfg_we         <= 1'b0;
        sample_ticks_r = st[CNT_W-1:0];
        windows_r      = wpr[CNT_W-1:0];
        gear_r         = gear[GEAR_W-1:0];
        ppr_r          = ppr[PPR_W-1:0];
        settings_used++;
    endtask

    initial
    begin
        dir_row_t    dir_rows [13];
        phase_t      plan [9];
        enc_word_t   w;
        speed_word_t zero_word;
        int          up_l;
        int          up_r;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_SAMPLE_TICKS;
        cfg_data               = '0;
        encoder_ch.valid       = 1'b0;
        encoder_ch.left_edge   = 1'b0;
        encoder_ch.left_phase  = 1'b0;
        encoder_ch.right_edge  = 1'b0;
        encoder_ch.right_phase = 1'b0;
        encoder_ch.ms_tick     = 1'b0;
        speed_ch.ready         = 1'b0;
        zero_word              = '0;

        sample_ticks_r = SAMPLE_TICKS_RST;
        windows_r      = WINDOWS_RST;
        gear_r         = GEAR_RST;
        ppr_r          = PPR_RST;
        left_pos       = '0;
        right_pos      = '0;
        left_last      = '0;
        right_last     = '0;
        left_acc       = '0;
        right_acc      = '0;
        tick_cnt       = '0;
        window_cnt     = '0;
        left_delta     = '0;
        right_delta    = '0;
        left_rpm       = '0;
        right_rpm      = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one window per tick, report every two windows, unit scaling
        program_meter(12'd1, 12'd2, 12'd1, 12'd1);

        // {left_edge, left_phase, right_edge, right_phase, ms_tick}
        dir_rows = '{
            '{5'b00000, 1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
            '{5'b11100, 1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
            '{5'b01010, 1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
            '{5'b00001, 1'b1, {16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b0}},
            '{5'b11101, 1'b1, {16'sd1, -16'sd1, 16'sd120, -16'sd120, 1'b1, 1'b1}},
            '{5'b00001, 1'b1, {16'sd0, 16'sd0, 16'sd120, -16'sd120, 1'b1, 1'b0}},
            '{5'b11111, 1'b1, {16'sd1, 16'sd1, 16'sd60, 16'sd60, 1'b1, 1'b1}},
            '{5'b10001, 1'b0, zero_word},
            '{5'b00100, 1'b0, zero_word},
            '{5'b00111, 1'b0, zero_word},
            '{5'b01011, 1'b0, zero_word},
            '{5'b11110, 1'b0, zero_word},
            '{5'b10101, 1'b0, zero_word}
        };
        foreach (dir_rows[i])
            apply_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].want);
        wait_idle();

        plan = '{
            '{12'd10, 12'd100, 12'd30, 12'd13, 50},
            '{12'd1, 12'd1, 12'd1, 12'd1, 50},
            '{12'd0, 12'd0, 12'd0, 12'd0, 50},
            '{12'd3, 12'd2, 12'd7, 12'd13, 60},
            '{12'd1023, 12'd1023, 12'd255, 12'd4095, 90},
            '{12'd2, 12'd3, 12'd255, 12'd4095, 50},
            '{12'd0, 12'd0, 12'd0, 12'd0, 40},
            '{12'd4, 12'd5, 12'd2, 12'd100, 70},
            '{12'd0, 12'd0, 12'd0, 12'd0, 60}
        };
        plan[6].st   = CFG_DATA_W'($urandom_range(0, 4095));
        plan[6].wpr  = CFG_DATA_W'($urandom_range(0, 4095));
        plan[6].gear = CFG_DATA_W'($urandom_range(0, 4095));
        plan[6].ppr  = CFG_DATA_W'($urandom_range(0, 4095));
        plan[8].st   = CFG_DATA_W'($urandom_range(1, 4));
        plan[8].wpr  = CFG_DATA_W'($urandom_range(1, 4));
        plan[8].gear = CFG_DATA_W'($urandom_range(1, 255));
        plan[8].ppr  = CFG_DATA_W'($urandom_range(1, 4095));

        foreach (plan[ph])
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            program_meter(plan[ph].st, plan[ph].wpr, plan[ph].gear, plan[ph].ppr);
            up_l = $urandom_range(0, 100);
            up_r = $urandom_range(0, 100);
            repeat (90)
            begin
                w.left_edge   = $urandom_range(0, 99) < 60;
                w.left_phase  = $urandom_range(0, 99) < up_l;
                w.right_edge  = $urandom_range(0, 99) < 60;
                w.right_phase = $urandom_range(0, 99) < up_r;
                w.ms_tick     = $urandom_range(0, 99) < plan[ph].tick_pct;
                apply_word(w, 1'b0, zero_word);
            end
            wait_idle();
        end

        // drive both wheels hard in opposite directions through one window
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        program_meter(12'd1, 12'd1, 12'd1, 12'd1);
        repeat (560)
            apply_word(5'b11100, 1'b0, zero_word);
        apply_word(5'b00001, 1'b0, zero_word);
        repeat (20)
            apply_word(enc_word_t'(5'($urandom_range(0, 31))), 1'b0, zero_word);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("meter: %0d speed words checked over %0d register settings", words_checked,
                 settings_used);
        $display("meter: %0d window closes, %0d rpm reports, rpm saturation burst included",
                 window_closes, rpm_reports);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dsm_pkg.sv
hdl/dsm_in_if.sv
hdl/dsm_out_if.sv
hdl/dsm_div.sv
hdl/dual_encoder_speed_meter.sv
verif/tb_top.sv
